FILE: hw/rtl/rrts_pkg.sv
// shared types and constants for the round-robin thread scheduler
`timescale 1ns / 1ps
`default_nettype none
package rrts_pkg;
   localparam int unsigned SleepWidth = 32;

   typedef enum logic [1:0] {
      ST_UNUSED   = 2'd0,
      ST_RUNNING  = 2'd1,
      ST_SLEEPING = 2'd2,
      ST_WAITING  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      REQ_PICK   = 3'd0,
      REQ_CREATE = 3'd1,
      REQ_SLEEP  = 3'd2,
      REQ_TICK   = 3'd3,
      REQ_BLOCK  = 3'd4,
      REQ_POP    = 3'd5,
      REQ_NOP6   = 3'd6,
      REQ_NOP7   = 3'd7
   } req_kind_type;

   // per-slot command broadcast from the controller
   typedef struct packed {
      logic tick;      // count down if sleeping
      logic set_run;   // make running, clear count
      logic set_sleep; // make sleeping with given count (0 counts as 1)
      logic set_wait;  // make waiting
   } slot_cmd_type;
endpackage
`default_nettype wire

FILE: hw/rtl/rrts_slot_cell.sv
// one thread slot: status and sleep counter
`timescale 1ns / 1ps
`default_nettype none
module rrts_slot_cell #(
   parameter bit IsIdle = 1'b0
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire rrts_pkg::slot_cmd_type          cmd,
   input  wire logic [rrts_pkg::SleepWidth-1:0] sleep_len,
   output rrts_pkg::status_type                 status
);
   rrts_pkg::status_type                 status_ff, status_in;
   logic [rrts_pkg::SleepWidth-1:0]      count_ff, count_in;

   always_comb begin
      status_in = status_ff;
      count_in  = count_ff;
      if (!IsIdle) begin
         if (cmd.set_run) begin
            status_in = rrts_pkg::ST_RUNNING;
            count_in  = '0;
         end else if (cmd.set_sleep) begin
            status_in = rrts_pkg::ST_SLEEPING;
            count_in  = (sleep_len == '0) ? rrts_pkg::SleepWidth'(1) : sleep_len;
         end else if (cmd.set_wait) begin
            status_in = rrts_pkg::ST_WAITING;
         end else if (cmd.tick && status_ff == rrts_pkg::ST_SLEEPING && count_ff != '0) begin
            count_in = count_ff - rrts_pkg::SleepWidth'(1);
            if (count_ff == rrts_pkg::SleepWidth'(1)) status_in = rrts_pkg::ST_RUNNING;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= IsIdle ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_UNUSED;
         count_ff  <= '0;
      end else begin
         status_ff <= status_in;
         count_ff  <= count_in;
      end
   end

   assign status = status_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/round_robin_thread_scheduler_core.sv
// top level of the round-robin thread scheduler
//
// channel  dir  tdata fields (low bit up)                         handshake
// req      in   req_type[2:0] sleep_length[34:3]                   tvalid/tready
// rsp      out  done_ok[0] affected_slot[3:1] running_slot[6:4]    tvalid/tready
//               input_waiting[7]
//
// pick and create scan one slot per cycle, up to THREAD_SLOTS slots per request
// sleep, tick, block and pop skip the scan and execute directly; one request at a time
// reset is synchronous: user slots unused, idle current, empty waiter queue
// a stalled response holds; the next request is taken once it is delivered
`timescale 1ns / 1ps
`default_nettype none
module round_robin_thread_scheduler_core #(
   parameter int unsigned THREAD_SLOTS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // req_type, sleep_length, zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata   // done_ok, affected_slot, running_slot, input_waiting
);
   localparam int unsigned SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
   localparam int unsigned CW = $clog2(THREAD_SLOTS + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC, S_RESP} state_type;

   state_type                   state_ff;
   rrts_pkg::req_kind_type      kind_ff;
   logic [rrts_pkg::SleepWidth-1:0] len_ff;
   logic [SW-1:0]               cursor_ff, probe_ff, current_ff, head_ff;
   logic [CW-1:0]               count_ff, steps_ff;
   logic [SW-1:0]               fifo_mem [THREAD_SLOTS];
   logic [SW-1:0]               pop_slot;
   logic                        ok_ff;
   logic [SW-1:0]               aff_ff;
   rrts_pkg::slot_cmd_type      cmd [THREAD_SLOTS];
   rrts_pkg::status_type        status [THREAD_SLOTS];
   logic [SW-1:0]               tail;
   logic [CW:0]                 tail_sum;

   function automatic logic [SW-1:0] nxt(input logic [SW-1:0] i);
      nxt = (32'(i) == THREAD_SLOTS - 1) ? '0 : i + SW'(1);
   endfunction

   assign tail_sum   = (CW+1)'(head_ff) + (CW+1)'(count_ff);
   assign tail       = (32'(tail_sum) >= THREAD_SLOTS) ? SW'(32'(tail_sum) - THREAD_SLOTS)
                                                       : SW'(tail_sum);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {count_ff != '0, 3'(current_ff), 3'(aff_ff), ok_ff};

   always_ff @(posedge clock) begin
      pop_slot <= fifo_mem[head_ff];
      if (state_ff == S_EXEC && kind_ff == rrts_pkg::REQ_BLOCK && current_ff != '0
          && status[current_ff] != rrts_pkg::ST_WAITING && 32'(count_ff) < THREAD_SLOTS)
         fifo_mem[tail] <= current_ff;
   end

   genvar g;
   for (g = 0; g < THREAD_SLOTS; g++) begin : g_slot
      always_comb begin
         cmd[g] = '0;
         if (state_ff == S_EXEC) begin
            unique case (kind_ff)
               rrts_pkg::REQ_TICK:  cmd[g].tick = 1'b1;
               rrts_pkg::REQ_SLEEP: cmd[g].set_sleep = (32'(current_ff) == g);
               rrts_pkg::REQ_BLOCK: cmd[g].set_wait = (32'(current_ff) == g);
               rrts_pkg::REQ_POP:   cmd[g].set_run = (count_ff != '0) && (32'(pop_slot) == g);
               default: ;
            endcase
         end else if (state_ff == S_SCAN && kind_ff == rrts_pkg::REQ_CREATE) begin
            cmd[g].set_run = (32'(probe_ff) == g) && (g != 0)
                             && (status[g] == rrts_pkg::ST_UNUSED);
         end
      end
      rrts_slot_cell #(.IsIdle(g == 0)) u_cell (
         .clock(clock), .reset(reset), .cmd(cmd[g]), .sleep_len(len_ff),
         .status(status[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cursor_ff  <= SW'(1 % THREAD_SLOTS);
         current_ff <= '0;
         head_ff    <= '0;
         count_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               kind_ff  <= rrts_pkg::req_kind_type'(req_tdata[2:0]);
               len_ff   <= req_tdata[34:3];
               probe_ff <= cursor_ff;
               steps_ff <= '0;
               ok_ff    <= 1'b0;
               aff_ff   <= '0;
               state_ff <= (req_tdata[2:0] == rrts_pkg::REQ_PICK ||
                            req_tdata[2:0] == rrts_pkg::REQ_CREATE) ? S_SCAN : S_EXEC;
            end
            S_SCAN: begin
               if (32'(steps_ff) == THREAD_SLOTS) begin
                  if (kind_ff == rrts_pkg::REQ_PICK) current_ff <= '0;
                  state_ff <= S_RESP;
               end else if (probe_ff != '0 && kind_ff == rrts_pkg::REQ_PICK
                            && status[probe_ff] == rrts_pkg::ST_RUNNING) begin
                  current_ff <= probe_ff;
                  cursor_ff  <= nxt(probe_ff);
                  state_ff   <= S_RESP;
               end else if (probe_ff != '0 && kind_ff == rrts_pkg::REQ_CREATE
                            && status[probe_ff] == rrts_pkg::ST_UNUSED) begin
                  ok_ff    <= 1'b1;
                  aff_ff   <= probe_ff;
                  state_ff <= S_RESP;
               end else begin
                  probe_ff <= nxt(probe_ff);
                  steps_ff <= steps_ff + CW'(1);
               end
            end
            S_EXEC: begin
               if (kind_ff == rrts_pkg::REQ_BLOCK && current_ff != '0) begin
                  ok_ff <= 1'b1;
                  if (status[current_ff] != rrts_pkg::ST_WAITING
                      && 32'(count_ff) < THREAD_SLOTS)
                     count_ff <= count_ff + CW'(1);
               end
               if (kind_ff == rrts_pkg::REQ_POP && count_ff != '0) begin
                  ok_ff    <= 1'b1;
                  aff_ff   <= pop_slot;
                  head_ff  <= nxt(head_ff);
                  count_ff <= count_ff - CW'(1);
               end
               state_ff <= S_RESP;
            end
            S_RESP: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= THREAD_SLOTS) else $error("waiter count overflow");
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("request and response both open");
   a_ok_aff: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:1] != 3'd0 |-> rsp_tdata[0]) else $error("slot without ok");
`endif
endmodule
`default_nettype wire
